// ===== rtl/core/pdtf_pkg.sv =====
// Package for the phase driven transport with faders.
// Holds fixed-point formats, command and register codes, and shared types.
// No dependencies.
package pdtf_pkg;

	localparam int FRAC_BITS  = 24;
	localparam int BAR_BITS   = 16;
	localparam int TIME_W     = BAR_BITS + FRAC_BITS;
	localparam int PHASE_BITS = 24;
	localparam int SCALE_W    = 24;
	localparam int SCALE_FRAC = 16;
	localparam int LOOP_W     = 39;
	localparam int GAIN_W     = 24;
	localparam int LEVEL_W    = 32;
	localparam int GAIN_SHIFT = LEVEL_W - GAIN_W;
	localparam int DUR_W      = 24;
	localparam int CMD_W      = 2;
	localparam int DIFF_W     = LEVEL_W + 1;
	localparam int DVD_W      = DIFF_W;
	localparam int CNT_W      = $clog2(DVD_W + 1);
	localparam int DPH_W      = PHASE_BITS + 1;
	localparam int PROD_W     = SCALE_W + 1 + DPH_W;
	localparam int INC_SHIFT  = SCALE_FRAC + PHASE_BITS - FRAC_BITS;
	localparam int INC_W      = PROD_W - INC_SHIFT;
	localparam int CFG_W      = LOOP_W;
	localparam int CFG_IDX_W  = 1;

	// input tdata layout, lowest bits first
	localparam int PHASE_LO  = 0;
	localparam int SET_LO    = PHASE_LO + PHASE_BITS;
	localparam int TARGET_LO = SET_LO + TIME_W;
	localparam int DUR_LO    = TARGET_LO + GAIN_W;
	localparam int IN_USED_W = DUR_LO + DUR_W;
	localparam int IN_DATA_W = ((IN_USED_W + 7) / 8) * 8;

	// output tdata layout, lowest bits first
	localparam int BAR_LO     = TIME_W;
	localparam int CHG_LO     = BAR_LO + BAR_BITS;
	localparam int MASTER_LO  = CHG_LO + 1;
	localparam int AUX_LO     = MASTER_LO + GAIN_W;
	localparam int OUT_USED_W = AUX_LO + GAIN_W;
	localparam int OUT_DATA_W = ((OUT_USED_W + 7) / 8) * 8;

	typedef logic [CMD_W-1:0] cmd_t;
	localparam cmd_t CMD_TICK        = 2'd0;
	localparam cmd_t CMD_SET_TIME    = 2'd1;
	localparam cmd_t CMD_MASTER_FADE = 2'd2;
	localparam cmd_t CMD_AUX_FADE    = 2'd3;

	typedef logic [CFG_IDX_W-1:0] reg_idx_t;
	localparam reg_idx_t REG_TIME_SCALE  = 1'd0;
	localparam reg_idx_t REG_LOOP_LENGTH = 1'd1;

	localparam logic [SCALE_W-1:0] TIME_SCALE_RESET = SCALE_W'(1) << SCALE_FRAC;
	localparam logic signed [TIME_W-1:0] TIME_RESET = {{BAR_BITS{1'b1}}, {FRAC_BITS{1'b0}}};
	localparam logic signed [BAR_BITS-1:0] LAST_BAR_RESET = BAR_BITS'(-100);

	typedef struct packed {
		logic              start;
		logic [DVD_W-1:0]  dividend;
		logic [DUR_W-1:0]  divisor;
	} div_req_t;

	typedef struct packed {
		logic signed [GAIN_W-1:0]   aux_gain;
		logic signed [GAIN_W-1:0]   master_gain;
		logic                       bar_changed;
		logic signed [BAR_BITS-1:0] bar_number;
		logic signed [TIME_W-1:0]   time_position;
	} result_t;

endpackage

// ===== rtl/core/pdtf_div.sv =====
// Shared restoring divider, one quotient bit per cycle.
// Depends on pdtf_pkg for widths and the request struct.
module pdtf_div import pdtf_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  div_req_t         req,
	output logic             done,
	output logic [DVD_W-1:0] quotient
);

	logic [DUR_W-1:0] rem_q;
	logic [DUR_W-1:0] dvs_q;
	logic [DVD_W-1:0] quo_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [DUR_W:0]   trial;
	logic             fits;

	assign trial = {rem_q, quo_q[DVD_W-1]};
	assign fits  = trial >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(DVD_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			dvs_q <= req.divisor;
			quo_q <= req.dividend;
		end else if (busy_q) begin
			rem_q <= fits ? DUR_W'(trial - {1'b0, dvs_q}) : trial[DUR_W-1:0];
			quo_q <= {quo_q[DVD_W-2:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

// ===== rtl/core/pdtf_seq.sv =====
// Sequencer and state of the transport: phase fold, scale, accumulate, wrap,
// gain ramps and ramp setup through the shared divider. Depends on pdtf_pkg.
module pdtf_seq import pdtf_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  cmd_t                     in_cmd,
	input  logic [PHASE_BITS-1:0]    in_phase,
	input  logic signed [TIME_W-1:0] in_set_time,
	input  logic signed [GAIN_W-1:0] in_target,
	input  logic [DUR_W-1:0]         in_duration,
	input  logic [SCALE_W-1:0]       time_scale,
	input  logic [LOOP_W-1:0]        loop_length,
	input  logic                     out_free,
	output logic                     res_valid,
	output result_t                  res,
	output div_req_t                 div_req,
	input  logic                     div_done,
	input  logic [DVD_W-1:0]         div_quo
);

	typedef enum logic [3:0] {
		S_IDLE, S_FOLD, S_MUL, S_ADD, S_WRAP, S_OUT, S_DIFF, S_ABS, S_DIV, S_STEP
	} state_t;

	localparam logic signed [DPH_W-1:0] PH_HALF = DPH_W'(1) << (PHASE_BITS - 1);
	localparam logic signed [DPH_W-1:0] PH_FULL = DPH_W'(1) << PHASE_BITS;
	localparam logic signed [LEVEL_W-1:0] LVL_MAX = {1'b0, {(LEVEL_W-1){1'b1}}};
	localparam logic signed [LEVEL_W-1:0] LVL_MIN = {1'b1, {(LEVEL_W-1){1'b0}}};
	localparam logic signed [TIME_W-1:0] T_MAX = {1'b0, {(TIME_W-1){1'b1}}};
	localparam logic signed [TIME_W-1:0] T_MIN = {1'b1, {(TIME_W-1){1'b0}}};

	state_t state_q;
	cmd_t   cmd_q;
	logic [PHASE_BITS-1:0]    phase_q;
	logic [PHASE_BITS-1:0]    prev_phase_q;
	logic signed [GAIN_W-1:0] target_q;
	logic [DUR_W-1:0]         dur_q;
	logic signed [DPH_W-1:0]  dph_q;
	logic signed [PROD_W-1:0] prod_q;
	logic signed [TIME_W-1:0] tsat_q;
	logic signed [TIME_W-1:0] time_pos_q;
	logic signed [BAR_BITS-1:0] last_bar_q;
	logic signed [LEVEL_W-1:0] m_level_q, m_step_q, a_level_q, a_step_q;
	logic [DUR_W-1:0]         m_left_q, a_left_q;
	logic signed [DIFF_W-1:0] diff_q;
	logic                     neg_q;
	logic                     res_valid_q;
	result_t                  res_q;
	div_req_t                 div_req_q;

	logic signed [DPH_W-1:0]    dph;
	logic signed [INC_W-1:0]    inc;
	logic signed [TIME_W:0]     tsum;
	logic signed [TIME_W-1:0]   tsat;
	logic                       wrap;
	logic signed [LEVEL_W:0]    m_sum, a_sum;
	logic signed [LEVEL_W-1:0]  m_next, a_next, sel_level;
	logic signed [LEVEL_W-1:0]  tgt_level;
	logic signed [LEVEL_W+1:0]  quo_signed;
	logic signed [LEVEL_W-1:0]  step_sat;
	logic signed [BAR_BITS-1:0] bar;

	function automatic logic signed [LEVEL_W-1:0] sat_level(input logic signed [LEVEL_W:0] v);
		if (v[LEVEL_W] != v[LEVEL_W-1])
			return v[LEVEL_W] ? LVL_MIN : LVL_MAX;
		return v[LEVEL_W-1:0];
	endfunction

	always_comb begin
		dph = $signed({1'b0, phase_q}) - $signed({1'b0, prev_phase_q});
		if (dph < -PH_HALF)
			dph = dph + PH_FULL;
		else if (dph > PH_HALF)
			dph = dph - PH_FULL;
	end

	assign inc  = prod_q[PROD_W-1:INC_SHIFT];
	assign tsum = $signed({time_pos_q[TIME_W-1], time_pos_q}) + (TIME_W+1)'(inc);
	assign tsat = (tsum[TIME_W] != tsum[TIME_W-1]) ? (tsum[TIME_W] ? T_MIN : T_MAX)
		: tsum[TIME_W-1:0];
	assign wrap = (loop_length != '0) && !tsat_q[TIME_W-1]
		&& (tsat_q[TIME_W-2:0] >= loop_length);

	assign m_sum  = $signed({m_level_q[LEVEL_W-1], m_level_q})
		+ $signed({m_step_q[LEVEL_W-1], m_step_q});
	assign a_sum  = $signed({a_level_q[LEVEL_W-1], a_level_q})
		+ $signed({a_step_q[LEVEL_W-1], a_step_q});
	assign m_next = sat_level(m_sum);
	assign a_next = sat_level(a_sum);

	assign sel_level  = (cmd_q == CMD_AUX_FADE) ? a_level_q : m_level_q;
	assign tgt_level  = {target_q, {GAIN_SHIFT{1'b0}}};
	assign quo_signed = neg_q ? -$signed({1'b0, div_quo}) : $signed({1'b0, div_quo});
	assign step_sat   = (quo_signed > (LEVEL_W+2)'(LVL_MAX)) ? LVL_MAX
		: (quo_signed < (LEVEL_W+2)'(LVL_MIN)) ? LVL_MIN : quo_signed[LEVEL_W-1:0];
	assign bar = time_pos_q[TIME_W-1:FRAC_BITS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			time_pos_q   <= TIME_RESET;
			prev_phase_q <= '0;
			last_bar_q   <= LAST_BAR_RESET;
			m_level_q    <= '0;
			m_step_q     <= '0;
			m_left_q     <= '0;
			a_level_q    <= '0;
			a_step_q     <= '0;
			a_left_q     <= '0;
			res_valid_q  <= 1'b0;
			div_req_q    <= '0;
		end else begin
			res_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						cmd_q    <= in_cmd;
						phase_q  <= in_phase;
						target_q <= in_target;
						dur_q    <= in_duration;
						case (in_cmd)
							CMD_TICK:     state_q <= S_FOLD;
							CMD_SET_TIME: time_pos_q <= in_set_time;
							default:      state_q <= S_DIFF;
						endcase
					end
				end
				S_FOLD: begin
					dph_q        <= dph;
					prev_phase_q <= phase_q;
					state_q      <= S_MUL;
				end
				S_MUL: begin
					prod_q  <= $signed({1'b0, time_scale}) * dph_q;
					state_q <= S_ADD;
				end
				S_ADD: begin
					tsat_q  <= tsat;
					state_q <= S_WRAP;
				end
				S_WRAP: begin
					time_pos_q <= wrap ? '0 : tsat_q;
					if (m_left_q != '0) begin
						m_level_q <= m_next;
						m_left_q  <= m_left_q - 1'b1;
					end
					if (a_left_q != '0) begin
						a_level_q <= a_next;
						a_left_q  <= a_left_q - 1'b1;
					end
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (out_free) begin
						res_valid_q         <= 1'b1;
						res_q.time_position <= time_pos_q;
						res_q.bar_number    <= bar;
						res_q.bar_changed   <= bar != last_bar_q;
						res_q.master_gain   <= m_level_q[LEVEL_W-1:GAIN_SHIFT];
						res_q.aux_gain      <= a_level_q[LEVEL_W-1:GAIN_SHIFT];
						last_bar_q          <= bar;
						state_q             <= S_IDLE;
					end
				end
				S_DIFF: begin
					diff_q <= $signed({tgt_level[LEVEL_W-1], tgt_level})
						- $signed({sel_level[LEVEL_W-1], sel_level});
					if (dur_q == '0) begin
						if (cmd_q == CMD_AUX_FADE) begin
							a_step_q <= '0;
							a_left_q <= '0;
						end else begin
							m_step_q <= '0;
							m_left_q <= '0;
						end
						state_q <= S_IDLE;
					end else begin
						state_q <= S_ABS;
					end
				end
				S_ABS: begin
					neg_q              <= diff_q[DIFF_W-1];
					div_req_q.start    <= 1'b1;
					div_req_q.dividend <= diff_q[DIFF_W-1] ? DVD_W'(-diff_q) : DVD_W'(diff_q);
					div_req_q.divisor  <= dur_q;
					state_q            <= S_DIV;
				end
				S_DIV: begin
					div_req_q.start <= 1'b0;
					if (div_done)
						state_q <= S_STEP;
				end
				S_STEP: begin
					if (cmd_q == CMD_AUX_FADE) begin
						a_step_q <= step_sat;
						a_left_q <= dur_q;
					end else begin
						m_step_q <= step_sat;
						m_left_q <= dur_q;
					end
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign in_ready  = state_q == S_IDLE;
	assign res_valid = res_valid_q;
	assign res       = res_q;
	assign div_req   = div_req_q;

endmodule

// ===== rtl/core/phase_driven_transport_with_faders_unit.sv =====
// Phase driven musical transport with master and aux gain faders.
//
// Channels: s_* takes one item per command; s_tuser holds the command (tick,
// set time, start master/aux fade). Only ticks give an m_* item, one each.
// The user must write time_scale (index 0) and loop_length (index 1) through
// cfg_we/cfg_index/cfg_wdata only while the block idles; it is not enforced.
//
// Steps: a tick passes the fold, multiply, add, wrap and output states to the
// output register; no new command is taken before it leaves the output state.
// Set time is applied in the idle state. A fade start passes the diff, abs,
// divide and step states, waiting on the shared divider, which forms one
// quotient bit per cycle; a fade with zero duration ends in the diff state.
//
// Reset: time goes to minus one bar, gains, ramps and phase history to zero,
// time_scale to 1.0 and looping off. The output register parts the two sides:
// a stalled receiver holds the finished item in place while the next command
// is taken and worked; a tick then waits before its output step.
// Depends on pdtf_pkg, pdtf_seq and pdtf_div.
module phase_driven_transport_with_faders_unit import pdtf_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [IN_DATA_W-1:0]  s_tdata,  // phase, set_time, target_gain, duration_samples
	input  logic [CMD_W-1:0]      s_tuser,  // cmd
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OUT_DATA_W-1:0] m_tdata,  // time_position, bar_number, bar_changed,
	                                        // master_gain, aux_gain, zero fill
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_W-1:0]      cfg_wdata
);

	logic [SCALE_W-1:0]    time_scale_q;
	logic [LOOP_W-1:0]     loop_length_q;
	logic                  m_tvalid_q;
	logic [OUT_DATA_W-1:0] m_tdata_q;
	logic                  out_free;
	logic                  res_valid;
	result_t               res;
	div_req_t              div_req;
	logic                  div_done;
	logic [DVD_W-1:0]      div_quo;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			time_scale_q  <= TIME_SCALE_RESET;
			loop_length_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_TIME_SCALE:  time_scale_q  <= cfg_wdata[SCALE_W-1:0];
				REG_LOOP_LENGTH: loop_length_q <= cfg_wdata[LOOP_W-1:0];
				default: ;
			endcase
		end
	end

	assign out_free = !m_tvalid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (res_valid) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid)
			m_tdata_q <= {{(OUT_DATA_W-OUT_USED_W){1'b0}}, res.aux_gain, res.master_gain,
				res.bar_changed, res.bar_number, res.time_position};
	end

	pdtf_seq u_seq (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (s_tvalid),
		.in_ready    (s_tready),
		.in_cmd      (s_tuser),
		.in_phase    (s_tdata[PHASE_LO +: PHASE_BITS]),
		.in_set_time (s_tdata[SET_LO +: TIME_W]),
		.in_target   (s_tdata[TARGET_LO +: GAIN_W]),
		.in_duration (s_tdata[DUR_LO +: DUR_W]),
		.time_scale  (time_scale_q),
		.loop_length (loop_length_q),
		.out_free    (out_free),
		.res_valid   (res_valid),
		.res         (res),
		.div_req     (div_req),
		.div_done    (div_done),
		.div_quo     (div_quo)
	);

	pdtf_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (div_req),
		.done     (div_done),
		.quotient (div_quo)
	);

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

endmodule

// ===== rtl/core/pdtf_checker.sv =====
// Port-level checks for the transport unit, bound to the top level.
// Depends on pdtf_pkg for field positions and command codes.
module pdtf_checker import pdtf_pkg::*; (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  s_tvalid,
	input logic                  s_tready,
	input logic [CMD_W-1:0]      s_tuser,
	input logic                  m_tvalid,
	input logic                  m_tready,
	input logic [OUT_DATA_W-1:0] m_tdata
);

	a_reset_quiet: assert property (@(posedge clk) !arst_n |=> !m_tvalid)
		else $error("output valid during reset");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("stalled output item changed");

	a_tick_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && (s_tuser == CMD_TICK) |=> !s_tready)
		else $error("ready right after a tick");

	a_bar_floor: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[CHG_LO-1:BAR_LO] == m_tdata[TIME_W-1:FRAC_BITS])
		else $error("bar number is not the floor of the time");

endmodule

bind phase_driven_transport_with_faders_unit pdtf_checker u_pdtf_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tuser  (s_tuser),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
